### rtl/core/particle_sensor_frame_parser_core_macros.svh
// Assertion macros used by the frame parser core RTL.
`ifndef PARTICLE_SENSOR_FRAME_PARSER_CORE_MACROS_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define PSFP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psfp assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define PSFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psfp assertion failed");
`else
`define PSFP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define PSFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/psfp_pkg.sv
// Shared constants and types of the particle sensor frame parser.
`default_nettype none
package psfp_pkg;
    localparam int unsigned PAYLOAD_BYTES_DEF = 12;
    localparam int unsigned NUM_READINGS      = 6;

    localparam logic [7:0]  HDR_FIRST  = 8'h42;
    localparam logic [7:0]  HDR_SECOND = 8'h4D;

    // Fixed byte positions at the head of a frame.
    localparam logic [15:0] POS_HDR0   = 16'd0;
    localparam logic [15:0] POS_HDR1   = 16'd1;
    localparam logic [15:0] POS_LEN_HI = 16'd2;
    localparam logic [15:0] POS_LEN_LO = 16'd3;
    localparam logic [15:0] POS_PAYLOAD = 16'd4;

    typedef logic [15:0] t_word;

    typedef struct packed {
        logic                         bad;
        logic                         good;
        t_word [NUM_READINGS-1:0]     readings;
    } t_psfp_res;
endpackage
`default_nettype wire

### rtl/core/particle_sensor_frame_parser_core.sv
// Top level of the particle sensor frame parser.
// Usage:
//   The slave channel takes one received serial byte per beat on s_axis_tdata.
//   The master channel gives one result beat for every byte taken: the frame
//   good and frame bad flags on m_axis_tuser and the six held readings on
//   m_axis_tdata. A flag is set only on the beat of the byte that closes a frame.
//   A byte is held in the input register, is decoded against the frame state in
//   one pass and lands in the result register, from which its result is shown.
//   One byte per cycle is taken while the master side keeps taking results; the
//   single decode pass that updates the frame state sets this rate.
//   Reset clears the frame state, the payload store and the readings to zero
//   and empties both registers.
//   When the receiver stalls, the result holds and at most one more byte is
//   taken into the input register; s_axis_tready then drops until space opens.
`default_nettype none
module particle_sensor_frame_parser_core
    import psfp_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [95:0]       m_axis_tdata,   // pm1_standard, pm25_standard,
                                              // pm10_standard, pm1_atmos,
                                              // pm25_atmos, pm10_atmos
    output logic [1:0]        m_axis_tuser    // [0] frame_good, [1] frame_bad
);
    logic       in_valid;
    logic [7:0] in_byte;
    logic       can_load;
    logic       proc_en;
    t_psfp_res  res_next;
    t_psfp_res  res_out;

    assign proc_en = in_valid && can_load;

    psfp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .o_valid   (in_valid),
        .o_data    (in_byte),
        .i_advance (can_load)
    );

    psfp_parse #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc_en),
        .i_byte  (in_byte),
        .o_res   (res_next)
    );

    psfp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_valid),
        .i_res      (res_next),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (res_out)
    );

    assign m_axis_tdata = res_out.readings;
    assign m_axis_tuser = {res_out.bad, res_out.good};
endmodule
`default_nettype wire

### rtl/core/psfp_in_reg.sv
// Input register for received bytes.
`default_nettype none
module psfp_in_reg
    import psfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data,
    output logic            o_valid,
    output logic [7:0]      o_data,
    input  wire logic       i_advance
);
    logic       r_valid;
    logic [7:0] r_data;

    // Space opens as soon as the held byte moves on in this cycle.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

### rtl/core/psfp_parse.sv
// Frame state, payload store and checksum logic of the parser.
`default_nettype none
`include "particle_sensor_frame_parser_core_macros.svh"
module psfp_parse
    import psfp_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_byte,
    output t_psfp_res       o_res
);
    logic [15:0]              r_pos;
    logic [15:0]              r_len;
    logic [15:0]              r_sum;
    logic [15:0]              r_rsum;
    logic [7:0]               r_store [PAYLOAD_BYTES];
    t_word [NUM_READINGS-1:0] r_readings;

    logic [15:0]              n_pos;
    logic [15:0]              n_len;
    logic [15:0]              n_sum;
    logic [15:0]              n_rsum;
    t_word [NUM_READINGS-1:0] n_readings;
    logic                     n_good;
    logic                     n_bad;

    logic [16:0] cks_pos;
    logic [16:0] pos_ext;
    logic [15:0] offset;
    logic [15:0] rsum_full;
    logic        store_we;

    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_sum      = r_sum;
        n_rsum     = r_rsum;
        n_readings = r_readings;
        n_good     = 1'b0;
        n_bad      = 1'b0;
        store_we   = 1'b0;
        // The checksum position is kept at 17 bits so a huge length never matches.
        cks_pos    = {1'b0, r_len} + 17'd2;
        pos_ext    = {1'b0, r_pos};
        offset     = r_pos - POS_PAYLOAD;
        rsum_full  = r_rsum | {8'h00, i_byte};

        if (r_pos == POS_HDR0) begin
            if (i_byte == HDR_FIRST) begin
                n_sum = {8'h00, i_byte};
                n_pos = r_pos + 16'd1;
            end
        end else if (r_pos == POS_HDR1) begin
            // A wrong second byte restarts the hunt without retesting this byte.
            if (i_byte != HDR_SECOND) begin
                n_pos = POS_HDR0;
            end else begin
                n_sum = r_sum + {8'h00, i_byte};
                n_pos = r_pos + 16'd1;
            end
        end else if (r_pos == POS_LEN_HI) begin
            n_sum = r_sum + {8'h00, i_byte};
            n_len = {i_byte, 8'h00};
            n_pos = r_pos + 16'd1;
        end else if (r_pos == POS_LEN_LO) begin
            n_sum = r_sum + {8'h00, i_byte};
            n_len = r_len | {8'h00, i_byte};
            n_pos = r_pos + 16'd1;
        end else if (pos_ext == cks_pos) begin
            n_rsum = {i_byte, 8'h00};
            n_pos  = r_pos + 16'd1;
        end else if (pos_ext == cks_pos + 17'd1) begin
            n_rsum = rsum_full;
            if (r_sum == rsum_full) begin
                n_good = 1'b1;
                for (int i = 0; i < NUM_READINGS; i++) begin
                    n_readings[i] = {r_store[2*i], r_store[2*i+1]};
                end
            end else begin
                n_bad = 1'b1;
            end
            n_pos = POS_HDR0;
        end else begin
            n_sum    = r_sum + {8'h00, i_byte};
            store_we = (offset < 16'(PAYLOAD_BYTES));
            n_pos    = r_pos + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_len      <= '0;
            r_sum      <= '0;
            r_rsum     <= '0;
            r_readings <= '0;
        end else if (i_en) begin
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_sum      <= n_sum;
            r_rsum     <= n_rsum;
            r_readings <= n_readings;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                r_store[k] <= '0;
            end
        end else begin
            for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                if (i_en && store_we && offset == 16'(k)) begin
                    r_store[k] <= i_byte;
                end
            end
        end
    end

    assign o_res.good     = n_good;
    assign o_res.bad      = n_bad;
    assign o_res.readings = n_readings;

    `PSFP_ASSERT_NEXT(a_end_restarts, i_clk, i_rst_n, i_en && (n_good || n_bad), r_pos == POS_HDR0)
    `PSFP_ASSERT_IMPLY(a_readings_on_good, i_clk, i_rst_n, !$stable(r_readings), $past(i_en && n_good))
    `PSFP_ASSERT_NEXT(a_header_sum, i_clk, i_rst_n, i_en && r_pos == POS_HDR1 && i_byte == HDR_SECOND, r_sum == 16'h008F)
endmodule
`default_nettype wire

### rtl/core/psfp_out_reg.sv
// Result register toward the downstream receiver.
`default_nettype none
module psfp_out_reg
    import psfp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  t_psfp_res      i_res,
    output logic           o_can_load,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_psfp_res      o_res
);
    logic      r_valid;
    t_psfp_res r_res;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule
`default_nettype wire

### tb/particle_sensor_frame_parser_core_checker.sv
// Scoreboard for the frame parser: predicts each result beat from the bytes taken and compares.
`timescale 1ns / 100ps
module particle_sensor_frame_parser_core_checker
    import psfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] rx_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,    // pm1_standard .. pm10_atmos, 16 bits each
    input  logic [1:0]  i_m_tuser,    // [0] frame_good, [1] frame_bad
    output int          o_fail_count,
    output int          o_pending
);
    logic [15:0] frame_pos;
    logic [15:0] frame_len;
    logic [15:0] byte_sum;
    logic [15:0] sum_rx;
    logic [7:0]  payload_bytes [PAYLOAD_BYTES_DEF];
    t_word       held_pm [NUM_READINGS];

    t_psfp_res   pending_results [$];
    int          mismatches = 0;

    string pm_names [NUM_READINGS] = '{"pm1_standard", "pm25_standard", "pm10_standard",
                                       "pm1_atmos", "pm25_atmos", "pm10_atmos"};

    task automatic note_mismatch(input string label, input logic [15:0] want,
                                 input logic [15:0] got);
        if (mismatches < 10) begin
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, label, want, got);
        end
        mismatches++;
    endtask

    // Advances the frame state by one byte and gives the result beat it causes.
    task automatic parse_byte(input logic [7:0] b, output t_psfp_res res);
        logic [16:0] pos_wide;
        logic [16:0] sum_pos;
        logic        step;
        res      = '0;
        step     = 1'b1;
        pos_wide = {1'b0, frame_pos};
        // The checksum position is worked out one bit wider so a huge length never matches.
        sum_pos  = {1'b0, frame_len} + 17'd2;
        if (frame_pos == POS_HDR0) begin
            if (b != HDR_FIRST) begin
                step = 1'b0;
            end else begin
                byte_sum = {8'h00, b};
            end
        end else if (frame_pos == POS_HDR1) begin
            // A wrong second header byte is dropped, not retried as a first one.
            if (b != HDR_SECOND) begin
                frame_pos = POS_HDR0;
                step      = 1'b0;
            end else begin
                byte_sum = byte_sum + {8'h00, b};
            end
        end else if (frame_pos == POS_LEN_HI) begin
            byte_sum  = byte_sum + {8'h00, b};
            frame_len = {b, 8'h00};
        end else if (frame_pos == POS_LEN_LO) begin
            frame_len = frame_len | {8'h00, b};
            byte_sum  = byte_sum + {8'h00, b};
        end else if (pos_wide == sum_pos) begin
            sum_rx = {b, 8'h00};
        end else if (pos_wide == sum_pos + 17'd1) begin
            sum_rx = sum_rx | {8'h00, b};
            if (byte_sum == sum_rx) begin
                for (int k = 0; k < NUM_READINGS; k++) begin
                    held_pm[k] = {payload_bytes[2*k], payload_bytes[2*k+1]};
                end
                res.good = 1'b1;
            end else begin
                res.bad = 1'b1;
            end
            frame_pos = POS_HDR0;
            step      = 1'b0;
        end else begin
            byte_sum = byte_sum + {8'h00, b};
            if (frame_pos < POS_PAYLOAD + PAYLOAD_BYTES_DEF) begin
                payload_bytes[frame_pos - POS_PAYLOAD] = b;
            end
        end
        if (step) begin
            frame_pos = frame_pos + 16'd1;
        end
        for (int k = 0; k < NUM_READINGS; k++) begin
            res.readings[k] = held_pm[k];
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_psfp_res want;
        if (!i_rst_n) begin
            frame_pos = '0;
            frame_len = '0;
            byte_sum  = '0;
            sum_rx    = '0;
            for (int k = 0; k < PAYLOAD_BYTES_DEF; k++) begin
                payload_bytes[k] = '0;
            end
            for (int k = 0; k < NUM_READINGS; k++) begin
                held_pm[k] = '0;
            end
            pending_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("unexpected result beat", 16'h0, 16'h0);
                end else begin
                    want = pending_results.pop_front();
                    if (want.good != i_m_tuser[0]) begin
                        note_mismatch("frame_good", {15'h0, want.good}, {15'h0, i_m_tuser[0]});
                    end
                    if (want.bad != i_m_tuser[1]) begin
                        note_mismatch("frame_bad", {15'h0, want.bad}, {15'h0, i_m_tuser[1]});
                    end
                    for (int k = 0; k < NUM_READINGS; k++) begin
                        if (want.readings[k] != i_m_tdata[16*k +: 16]) begin
                            note_mismatch(pm_names[k], want.readings[k], i_m_tdata[16*k +: 16]);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                parse_byte(i_s_tdata, want);
                pending_results.push_back(want);
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= mismatches;
    end
endmodule

### tb/particle_sensor_frame_parser_core_tb.sv
// Top of the frame parser testbench: clock, reset, byte stimulus, result stalls and verdict.
`timescale 1ns / 100ps
module particle_sensor_frame_parser_core_tb;
    import psfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 100_000;
    localparam int          RANDOM_BYTES  = 700;
    localparam int          PRESS_CYCLES  = 300;
    localparam int          TAIL_BYTES    = 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] rx_byte
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [95:0] m_axis_tdata;             // pm1_standard .. pm10_atmos, 16 bits each
    logic [1:0]  m_axis_tuser;             // [0] frame_good, [1] frame_bad

    int          fail_count;
    int          pending;
    bit          press_go = 1'b0;
    bit          press_done = 1'b0;
    int          frame_bytes = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    particle_sensor_frame_parser_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    particle_sensor_frame_parser_core_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    // Valid stays high afterwards, so back-to-back beats are sent with no gap in valid.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = send_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_frame(input logic [15:0] len, input bit corrupt, input bit extremes);
        logic [15:0] sum;
        logic [7:0]  b;
        int          n;
        sum = {8'h00, HDR_FIRST} + {8'h00, HDR_SECOND} + {8'h00, len[15:8]} + {8'h00, len[7:0]};
        n   = (len >= 16'd2) ? int'(len) - 2 : 0;
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (int i = 0; i < n; i++) begin
            b   = extremes ? (i[0] ? 8'h00 : 8'hFF) : 8'($urandom);
            sum = sum + {8'h00, b};
            send_byte(b);
        end
        if (corrupt) begin
            sum = sum ^ 16'($urandom_range(1, 65535));
        end
        send_byte(sum[15:8]);
        send_byte(sum[7:0]);
        frame_bytes += n + 6;
    endtask

    initial begin : receiver
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (press_go && !press_done) begin
                // Long hold-off so the parser fills up and drops s_axis_tready.
                hold       = PRESS_CYCLES;
                press_done = 1'b1;
            end else if (hold == 0) begin
                hold = stall_len();
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("particle_sensor_frame_parser_core_tb: errors");
        $finish;
    end

    initial begin : stimulus
        int          pick;
        int          n;
        logic [7:0]  b;
        logic [15:0] len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full store of alternating all-ones and all-zeros bytes, good checksum.
        send_frame(16'd14, 1'b0, 1'b1);
        // Header retry: the repeated first header byte is not taken as a new start.
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        // Empty payload: the readings come from whatever the store held.
        send_frame(16'd2, 1'b0, 1'b0);

        press_go   = 1'b1;
        frame_bytes = 0;
        while (frame_bytes < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = ($urandom_range(0, 3) == 0) ? 16'd28 : 16'($urandom_range(2, 34));
                send_frame(len, $urandom_range(0, 99) < 15, 1'b0);
            end else if (pick < 80) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    send_byte(8'($urandom));
                end
                frame_bytes += n;
            end else if (pick < 90) begin
                do b = 8'($urandom); while (b == HDR_SECOND);
                send_byte(HDR_FIRST);
                send_byte(($urandom_range(0, 1) == 0) ? HDR_FIRST : b);
                frame_bytes += 2;
            end else begin
                // Frame cut short; the bytes that follow are taken as its remainder.
                len = 16'($urandom_range(6, 20));
                n   = $urandom_range(0, int'(len) - 3);
                send_byte(HDR_FIRST);
                send_byte(HDR_SECOND);
                send_byte(len[15:8]);
                send_byte(len[7:0]);
                for (int i = 0; i < n; i++) begin
                    send_byte(8'($urandom));
                end
                frame_bytes += n + 4;
            end
        end

        // A length of 0, 1, 0xFFFE or 0xFFFF never reaches the checksum, so every
        // later byte counts as payload; this runs last since no frame can follow.
        pick = $urandom_range(0, 3);
        len  = (pick < 2) ? 16'(pick) : 16'hFFFC + 16'(pick);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (int i = 0; i < TAIL_BYTES; i++) begin
            send_byte(8'($urandom));
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("particle_sensor_frame_parser_core_tb: clean");
        end else begin
            $display("particle_sensor_frame_parser_core_tb: errors");
        end
        $finish;
    end
endmodule

### particle_sensor_frame_parser_core.f
+incdir+rtl/core
rtl/core/psfp_pkg.sv
rtl/core/psfp_in_reg.sv
rtl/core/psfp_parse.sv
rtl/core/psfp_out_reg.sv
rtl/core/particle_sensor_frame_parser_core.sv
tb/particle_sensor_frame_parser_core_checker.sv
tb/particle_sensor_frame_parser_core_tb.sv
